// ===== hdl/wbb_pkg.sv =====
// ----------------------------------------------------------------------------
// wbb_pkg
// Shared types, constants and helpers for the white border bounding box.
// ----------------------------------------------------------------------------
package wbb_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W         = $clog2(MAX_DIMENSION);
	localparam int POS_W         = 12;
	localparam int SIZE_W        = 13;
	localparam int CHAN_W        = 8;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_WHITE_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 2'd2;

	localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd240;
	localparam logic [SIZE_W-1:0] WIDTH_RESET     = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 13'd480;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [POS_W-1:0]  crop_left;
		logic [POS_W-1:0]  crop_top;
		logic [SIZE_W-1:0] crop_width;
		logic [SIZE_W-1:0] crop_height;
		logic              all_white;
	} crop_t;

	// Settings as the tracker sees them: sizes already clamped, as last index
	typedef struct packed {
		logic [CHAN_W-1:0] threshold;
		logic [DIM_W-1:0]  last_col;
		logic [DIM_W-1:0]  last_row;
	} cfg_t;

	// Last index of a dimension: zero acts as one, oversize acts as the maximum
	function automatic logic [DIM_W-1:0] last_index(input logic [SIZE_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > MAX_DIMENSION) begin
			r = DIM_W'(MAX_DIMENSION - 1);
		end else begin
			r = DIM_W'(v - SIZE_W'(1));
		end
		return r;
	endfunction

endpackage

// ===== hdl/wbb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wbb_cfg_regs
// Configuration registers with clamped frame size decode.
// ----------------------------------------------------------------------------
module wbb_cfg_regs import wbb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	logic [CHAN_W-1:0] threshold_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			width_q     <= WIDTH_RESET;
			height_q    <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WHITE_THRESHOLD: threshold_q <= cfg_data[CHAN_W-1:0];
				REG_FRAME_WIDTH:     width_q     <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT:    height_q    <= cfg_data[SIZE_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	assign cfg.threshold = threshold_q;
	assign cfg.last_col  = last_index(width_q);
	assign cfg.last_row  = last_index(height_q);

endmodule

// ===== hdl/wbb_tracker.sv =====
// ----------------------------------------------------------------------------
// wbb_tracker
// Input register, raster position and bounding box tracking.
// ----------------------------------------------------------------------------
module wbb_tracker import wbb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  pixel_t in_pixel,
	output logic   result_valid,
	input  logic   result_ready,
	output crop_t  result
);

	logic             valid_s1;
	pixel_t           pixel_s1;
	logic [DIM_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic             seen_q;

	logic             white, row_end, frame_end, advance;
	logic [DIM_W-1:0] min_col_n, max_col_n, min_row_n, max_row_n;

	always_comb begin
		white = (pixel_s1.red >= cfg.threshold) && (pixel_s1.green >= cfg.threshold)
			&& (pixel_s1.blue >= cfg.threshold);
		row_end   = col_q >= cfg.last_col;
		frame_end = row_end && (row_q >= cfg.last_row);
		advance   = valid_s1 && (!frame_end || result_ready);
		in_ready  = !valid_s1 || advance;

		min_col_n = min_col_q;
		max_col_n = max_col_q;
		min_row_n = min_row_q;
		max_row_n = max_row_q;
		if (!white) begin
			if (!seen_q) begin
				min_col_n = col_q;
				max_col_n = col_q;
				min_row_n = row_q;
				max_row_n = row_q;
			end else begin
				if (col_q < min_col_q) min_col_n = col_q;
				if (col_q > max_col_q) max_col_n = col_q;
				if (row_q < min_row_q) min_row_n = row_q;
				if (row_q > max_row_q) max_row_n = row_q;
			end
		end
	end

	always_comb begin
		result_valid = valid_s1 && frame_end;
		if (seen_q || !white) begin
			result.crop_left   = POS_W'(min_col_n);
			result.crop_top    = POS_W'(min_row_n);
			result.crop_width  = SIZE_W'({1'b0, max_col_n} - {1'b0, min_col_n}
				+ (DIM_W+1)'(1));
			result.crop_height = SIZE_W'({1'b0, max_row_n} - {1'b0, min_row_n}
				+ (DIM_W+1)'(1));
			result.all_white   = 1'b0;
		end else begin
			result.crop_left   = '0;
			result.crop_top    = '0;
			result.crop_width  = SIZE_W'({1'b0, cfg.last_col} + (DIM_W+1)'(1));
			result.crop_height = SIZE_W'({1'b0, cfg.last_row} + (DIM_W+1)'(1));
			result.all_white   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) pixel_s1 <= in_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (advance) begin
			if (frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '1;
				max_col_q <= '0;
				min_row_q <= '1;
				max_row_q <= '0;
				seen_q    <= 1'b0;
			end else begin
				col_q     <= row_end ? '0 : col_q + DIM_W'(1);
				row_q     <= row_end ? row_q + DIM_W'(1) : row_q;
				min_col_q <= min_col_n;
				max_col_q <= max_col_n;
				min_row_q <= min_row_n;
				max_row_q <= max_row_n;
				seen_q    <= seen_q || !white;
			end
		end
	end

endmodule

// ===== hdl/white_border_bounding_box.sv =====
// ----------------------------------------------------------------------------
// white_border_bounding_box
// Content bounding box of a raster frame, for cropping away a white border.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (valid/ready), one item per pixel in
// raster order. A pixel is white when red, green and blue all reach the
// white threshold. At the last pixel of each frame one item leaves on the
// crop channel: the rectangle around every non-white pixel, or the whole
// frame with all_white set when there was none.
// The cfg channel writes the threshold, frame width and frame height; it is
// always ready, and writes belong in gaps when no item is in flight. A size
// change part way through a frame takes effect at once on the running frame.
// Throughput: one pixel per cycle while the crop channel is not stalled.
// Each pixel is held in the input register, where the compare and min/max
// update run; a frame's result then passes into the output register, from
// which it goes out on the crop channel.
// When the receiver stalls, the output register holds the result; pixels
// keep flowing until the next frame's last pixel, which waits in the input
// register and backs up the pixel channel.
// Reset clears both registers, the raster position and the tracking, and
// restores the threshold to 240 and the frame size to 640 by 480.
// ----------------------------------------------------------------------------
module white_border_bounding_box import wbb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pixel_valid,
	output logic                   pixel_ready,
	input  pixel_t                 pixel,
	output logic                   crop_valid,
	input  logic                   crop_ready,
	output crop_t                  crop,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t  cfg;
	logic  result_valid;
	logic  result_ready;
	crop_t result;
	logic  crop_valid_q;
	crop_t crop_q;

	// Settings registers
	wbb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register and tracking
	wbb_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (pixel_valid),
		.in_ready     (pixel_ready),
		.in_pixel     (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Output register: take a new result whenever it is empty or draining
	assign result_ready = !crop_valid_q || crop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_valid_q <= 1'b0;
		end else if (result_ready) begin
			crop_valid_q <= result_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (result_ready && result_valid) crop_q <= result;
	end

	assign crop_valid = crop_valid_q;
	assign crop       = crop_q;

endmodule
